// File: rtl/lpr_pkg.sv
// Shared types and constants of the linear PCM resampler.
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RATE_W      = 18;
	localparam int PHASE_W     = RATE_W + 1;
	localparam int RESULT_CAP  = 32;
	localparam int CNT_W       = $clog2(RESULT_CAP + 1);

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);

	localparam logic REG_SOURCE_RATE = 1'b0;
	localparam logic REG_TARGET_RATE = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t sample_in;
		logic    final_in;
	} lpr_in_t;

	typedef struct packed {
		sample_t sample_out;
		logic    sample_valid;
		logic    run_end;
		logic    stream_end;
		logic    ratio_error;
	} lpr_out_t;

endpackage
`default_nettype wire

// File: rtl/lpr_div.sv
// Restoring divider that forms the blend fraction one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lpr_div import lpr_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [RATE_W-1:0]        rem,
	input  wire logic [RATE_W-1:0]        dsr,
	output logic                          done,
	output logic [FRACTION_BITS-1:0]      quot
);

	localparam int CW = $clog2(FRACTION_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [RATE_W-1:0] r_q;
	logic [FRACTION_BITS-1:0] q_q;
	logic [RATE_W:0]   r2;
	logic [RATE_W:0]   diff;
	logic              ge;

	always_comb begin
		r2   = {r_q, 1'b0};
		ge   = r2 >= {1'b0, dsr};
		diff = r2 - {1'b0, dsr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRACTION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= rem;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[RATE_W-1:0] : r2[RATE_W-1:0];
			q_q <= {q_q[FRACTION_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule
`default_nettype wire

// File: rtl/linear_pcm_resampler.sv
// Linear-interpolation sample rate converter for signed PCM words.
//
// Each input word is taken only while the block is idle. Every interpolated output of an item
// passes through the shared restoring divider that forms its blend fraction, then a multiply
// and a blend step; an output that repeats the last sample at the end of a buffer skips these
// steps. Results leave through a one-word output register; a result is held back one step so
// that the last one of each item can carry run_end. Rates must be written through the
// configuration port only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module linear_pcm_resampler import lpr_pkg::*; #(
	parameter int FRACTION_BITS = 16,
	parameter int MAX_UPSAMPLE  = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lpr_in_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lpr_out_t               out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [RATE_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_LOOP1  = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_BLEND  = 4'd5;
	localparam logic [3:0] ST_STORE  = 4'd6;
	localparam logic [3:0] ST_FINCHK = 4'd7;
	localparam logic [3:0] ST_LOOP2  = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	localparam int UPW = RATE_W + $clog2(MAX_UPSAMPLE + 1);
	localparam int DW  = SAMPLE_BITS + 1;
	localparam int PW  = DW + FRACTION_BITS + 1;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

	logic [3:0]         state_q;
	logic [RATE_W-1:0]  src_q;
	logic [RATE_W-1:0]  dst_q;
	sample_t            held_q;
	logic               have_q;
	logic [PHASE_W-1:0] phase_q;
	sample_t            s_q;
	logic               fin_q;
	logic               loop2_q;
	logic [CNT_W-1:0]   n_q;
	lpr_out_t           pend_q;
	logic               pend_vld_q;
	sample_t            new_q;
	logic signed [PW-1:0] prod_q;
	logic               out_valid_q;
	lpr_out_t           out_q;

	logic               out_free;
	logic [UPW-1:0]     limit;
	logic               bad;
	logic               below;
	logic               cap_ok;
	logic               store_go;
	logic               done_go;
	logic               push_en;
	lpr_out_t           push_rec;
	lpr_out_t           new_rec;
	lpr_out_t           err_rec;
	logic               div_start;
	logic               div_done;
	logic [FRACTION_BITS-1:0] quot;
	logic signed [DW-1:0] diff;
	logic [PW-1:0]      rounded;
	logic [DW-1:0]      blended;

	lpr_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rem    (phase_q[RATE_W-1:0]),
		.dsr    (dst_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		out_free  = !out_valid_q || out_ready;
		limit     = UPW'(src_q) * UPW'(MAX_UPSAMPLE);
		bad       = (src_q == '0) || (dst_q == '0) || (UPW'(dst_q) > limit);
		below     = phase_q < PHASE_W'(dst_q);
		cap_ok    = n_q < CNT_W'(RESULT_CAP);
		store_go  = !cap_ok || !pend_vld_q || out_free;
		done_go   = out_free || (!pend_vld_q && !fin_q);
		div_start = (state_q == ST_LOOP1) && below;
		diff      = DW'(s_q) - DW'(held_q);
		rounded   = prod_q + HALF;
		blended   = DW'(held_q) + rounded[FRACTION_BITS +: DW];

		new_rec              = '0;
		new_rec.sample_out   = new_q;
		new_rec.sample_valid = 1'b1;
		err_rec              = '0;
		err_rec.ratio_error  = 1'b1;

		push_en  = 1'b0;
		push_rec = pend_q;
		if (state_q == ST_STORE) begin
			push_en = cap_ok && pend_vld_q && out_free;
		end else if (state_q == ST_DONE && out_free) begin
			if (pend_vld_q) begin
				push_en             = 1'b1;
				push_rec.run_end    = 1'b1;
				push_rec.stream_end = fin_q;
			end else if (fin_q) begin
				push_en             = 1'b1;
				push_rec            = '0;
				push_rec.run_end    = 1'b1;
				push_rec.stream_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= RATE_RESET;
			dst_q       <= RATE_RESET;
			state_q     <= ST_IDLE;
			held_q      <= '0;
			have_q      <= 1'b0;
			phase_q     <= '0;
			pend_vld_q  <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SOURCE_RATE: src_q <= cfg_data;
					REG_TARGET_RATE: dst_q <= cfg_data;
					default: ;
				endcase
			end
			if (push_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					n_q <= '0;
					if (bad) begin
						pend_vld_q <= 1'b1;
						state_q    <= ST_DONE;
					end else if (have_q) begin
						state_q <= ST_LOOP1;
					end else begin
						phase_q <= '0;
						held_q  <= s_q;
						have_q  <= 1'b1;
						state_q <= ST_FINCHK;
					end
				end
				ST_LOOP1: begin
					if (below) begin
						state_q <= ST_DIV;
					end else begin
						phase_q <= phase_q - PHASE_W'(dst_q);
						held_q  <= s_q;
						have_q  <= 1'b1;
						state_q <= ST_FINCHK;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_BLEND;
				ST_BLEND: state_q <= ST_STORE;
				ST_STORE: begin
					if (store_go) begin
						if (cap_ok) begin
							pend_vld_q <= 1'b1;
							n_q        <= n_q + CNT_W'(1);
						end
						phase_q <= phase_q + PHASE_W'(src_q);
						state_q <= loop2_q ? ST_LOOP2 : ST_LOOP1;
					end
				end
				ST_FINCHK: state_q <= fin_q ? ST_LOOP2 : ST_DONE;
				ST_LOOP2:  state_q <= below ? ST_STORE : ST_DONE;
				ST_DONE: begin
					if (done_go) begin
						pend_vld_q <= 1'b0;
						if (fin_q) begin
							held_q  <= '0;
							have_q  <= 1'b0;
							phase_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			s_q     <= in_data.sample_in;
			fin_q   <= in_data.final_in;
			loop2_q <= 1'b0;
		end
		if (state_q == ST_FINCHK) begin
			loop2_q <= 1'b1;
		end
		if (state_q == ST_CHECK && bad) begin
			pend_q <= err_rec;
		end
		if (state_q == ST_STORE && store_go && cap_ok) begin
			pend_q <= new_rec;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(diff) * $signed({1'b0, quot});
		end
		if (state_q == ST_BLEND) begin
			new_q <= blended[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_LOOP2) begin
			new_q <= s_q;
		end
		if (push_en) begin
			out_q <= push_rec;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: rtl/lpr_checker.sv
// Port-level checks of the resampler and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lpr_checker import lpr_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire lpr_out_t out_data
);

	// A word that waits at the output must not change under the consumer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// An error result carries no sample and closes the run of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ratio_error |-> !out_data.sample_valid && out_data.run_end)
		else $error("malformed error result");

	// The end of a buffer is always the end of the run of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stream_end |-> out_data.run_end)
		else $error("stream end without run end");

	// A result without a sample carries a zero sample field.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sample_valid |-> out_data.sample_out == '0)
		else $error("empty result with non-zero sample");

	// An accepted word is worked on before the next one is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind linear_pcm_resampler lpr_checker u_lpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: bench/tb_linear_pcm_resampler.sv
// Self-checking testbench for the linear PCM resampler, driven by directed and random streams.
`timescale 1ns / 1ps
module tb_linear_pcm_resampler;
	import lpr_pkg::*;

	localparam int FRAC_BITS    = 16;
	localparam int UPSAMPLE_MAX = 16;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 42;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	lpr_in_t           in_data;
	logic              out_valid;
	logic              out_ready;
	lpr_out_t          out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [RATE_W-1:0] cfg_data;

	logic [RATE_W-1:0]  cur_src     = RATE_RESET;
	logic [RATE_W-1:0]  cur_dst     = RATE_RESET;
	sample_t            last_sample = '0;
	logic               last_held   = 1'b0;
	logic [PHASE_W-1:0] pos_rem     = '0;

	lpr_out_t due_words[$];
	int       mismatches   = 0;
	bit       steady       = 1'b0;
	bit       hold_request = 1'b0;

	linear_pcm_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sample_t blend_pair(sample_t a, sample_t b, logic [PHASE_W-1:0] rem,
			logic [RATE_W-1:0] rate);
		longint unsigned frac, ua, ub, acc;
		frac = (64'(rem) << FRAC_BITS) / 64'(rate);
		ua = longint'(a) + (1 << (SAMPLE_BITS - 1));
		ub = longint'(b) + (1 << (SAMPLE_BITS - 1));
		acc = ua * ((64'd1 << FRAC_BITS) - frac) + ub * frac + (64'd1 << (FRAC_BITS - 1));
		return sample_t'((acc >> FRAC_BITS) - (64'd1 << (SAMPLE_BITS - 1)));
	endfunction

	function automatic lpr_out_t sample_word(sample_t s);
		return lpr_out_t'{sample_out: s, sample_valid: 1'b1, run_end: 1'b0, stream_end: 1'b0,
			ratio_error: 1'b0};
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic resample_item(input sample_t s, input logic fin);
		lpr_out_t words[$];
		if (cur_src == 0 || cur_dst == 0 || int'(cur_dst) > UPSAMPLE_MAX * int'(cur_src)) begin
			due_words.push_back(lpr_out_t'{sample_out: '0, sample_valid: 1'b0, run_end: 1'b1,
				stream_end: fin, ratio_error: 1'b1});
			if (fin)
				{last_sample, last_held, pos_rem} = '0;
			return;
		end
		if (last_held) begin
			while (pos_rem < cur_dst) begin
				if (words.size() < RESULT_CAP)
					words.push_back(sample_word(blend_pair(last_sample, s, pos_rem, cur_dst)));
				pos_rem += cur_src;
			end
			pos_rem -= cur_dst;
		end else begin
			pos_rem = '0;
		end
		last_sample = s;
		last_held   = 1'b1;
		if (fin) begin
			// Positions at or past the last word repeat it.
			while (pos_rem < cur_dst) begin
				if (words.size() < RESULT_CAP)
					words.push_back(sample_word(s));
				pos_rem += cur_src;
			end
			if (words.size() == 0)
				words.push_back(lpr_out_t'(0));
			words[words.size() - 1].stream_end = 1'b1;
			{last_sample, last_held, pos_rem} = '0;
		end
		if (words.size() != 0)
			words[words.size() - 1].run_end = 1'b1;
		foreach (words[i])
			due_words.push_back(words[i]);
	endtask

	task automatic note_mismatch(input string what, input lpr_out_t want, input lpr_out_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected sample %0d valid %b run %b end %b err %b,",
				$time, what, want.sample_out, want.sample_valid, want.run_end,
				want.stream_end, want.ratio_error,
				" got sample %0d valid %b run %b end %b err %b",
				got.sample_out, got.sample_valid, got.run_end, got.stream_end,
				got.ratio_error);
	endtask

	task automatic check_word(input lpr_out_t got);
		lpr_out_t want;
		want = '0;
		if (due_words.size() == 0) begin
			note_mismatch("unexpected word", want, got);
		end else begin
			want = due_words.pop_front();
			if (got.sample_out !== want.sample_out || got.sample_valid !== want.sample_valid ||
					got.run_end !== want.run_end || got.stream_end !== want.stream_end ||
					got.ratio_error !== want.ratio_error)
				note_mismatch("wrong word", want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_word(out_data);
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL linear_pcm_resampler");
		$finish;
	end

	task automatic send_word(input sample_t s, input logic fin);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data  <= lpr_in_t'{sample_in: s, final_in: fin};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		resample_item(s, fin);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		// A word that causes no result may still be in flight.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic idx, input logic [RATE_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SOURCE_RATE)
			cur_src = value;
		else
			cur_dst = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rates(input int src, input int dst);
		settle();
		write_rate(REG_SOURCE_RATE, RATE_W'(src));
		write_rate(REG_TARGET_RATE, RATE_W'(dst));
	endtask

	task automatic test_equal_rates();
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h5555, 1'b0);
		send_word(16'hAAAA, 1'b1);
		send_word(16'h1234, 1'b1);
	endtask

	task automatic test_upsample_max();
		set_rates(1000, 16000);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h7FFF, 1'b1);
	endtask

	task automatic test_downsample_marker();
		// The final word arrives with no output due, so only a marker comes back.
		set_rates(48000, 8000);
		send_word(rand_sample(), 1'b0);
		send_word(rand_sample(), 1'b0);
		send_word(rand_sample(), 1'b1);
	endtask

	task automatic test_unusable_rates();
		set_rates(1000, 16001);
		send_word(16'sd100, 1'b0);
		send_word(-16'sd100, 1'b1);
		set_rates(0, 16000);
		send_word(16'sd5, 1'b1);
		set_rates(1000, 0);
		send_word(16'sd7, 1'b0);
	endtask

	task automatic test_rate_change_mid_buffer();
		// The remainder is left above the new target rate and must run down.
		set_rates(7000, 3000);
		for (int i = 0; i < 4; i++)
			send_word(rand_sample(), 1'b0);
		set_rates(1000, 4000);
		send_word(rand_sample(), 1'b0);
		send_word(rand_sample(), 1'b0);
		send_word(rand_sample(), 1'b1);
	endtask

	task automatic test_backpressure();
		set_rates(8000, 128000);
		steady       = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 30; i++)
			send_word(rand_sample(), i == 29);
		steady = 1'b0;
	endtask

	task automatic test_random_streams();
		int src, dst, left;
		left = 0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin src = 1; dst = 16; end
				1: begin src = 192000; dst = 192000; end
				2: begin src = 192000; dst = 1; end
				3: begin src = 1; dst = 1; end
				4: begin src = 12000; dst = 192000; end
				5: begin src = 44100; dst = 48000; end
				6: begin
					src = $urandom_range(1, 192000);
					dst = $urandom_range(1, (src > 12000) ? 192000 : src * 16);
				end
				default: begin
					src = $urandom_range(1, 11999);
					dst = $urandom_range(src * 16 + 1, 192000);
				end
			endcase
			set_rates(src, dst);
			steady = (p == 3);
			// Buffers may straddle a rate change.
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (left == 0)
					left = $urandom_range(1, 12);
				left--;
				send_word(rand_sample(), left == 0);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SOURCE_RATE;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_equal_rates();
		test_upsample_max();
		test_downsample_marker();
		test_unusable_rates();
		test_rate_change_mid_buffer();
		test_backpressure();
		test_random_streams();
		settle();
		if (mismatches == 0 && due_words.size() == 0)
			$display("PASS linear_pcm_resampler");
		else
			$display("FAIL linear_pcm_resampler");
		$finish;
	end

endmodule
